// ===== rtl/aim_pkg.sv =====
// Shared types and constants for the array intersection match block.
// No dependencies; every other file imports this package.
package aim_pkg;

  localparam int STORE_DEPTH = 8;
  localparam int ROW_W       = 3;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 6;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [STORE_DEPTH-1:0]   mask_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [POS_W-1:0]         pos_t;

  // One row of compare hits passed from the lanes to the merge stage
  typedef struct packed {
    logic  wr;
    logic  fin;
    row_t  row;
    mask_t mask;
  } row_wr_t;

endpackage

// ===== rtl/aim_if.sv =====
// Valid/ready channel interfaces for the input pairs and the results.
// Depends on aim_pkg.
interface aim_in_if import aim_pkg::*;;
  logic  valid;
  logic  ready;
  data_t a_value;
  data_t b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

interface aim_out_if import aim_pkg::*;;
  logic  valid;
  logic  ready;
  data_t match_value;
  pos_t  out_position;
  logic  match_found;
  logic  last;

  modport source (output valid, output match_value, output out_position,
                  output match_found, output last, input ready);
  modport sink   (input valid, input match_value, input out_position,
                  input match_found, input last, output ready);
endinterface

// ===== rtl/aim_lane.sv =====
// One compare lane: holds one B element and tests it against the broadcast A.
// Depends on aim_pkg.
module aim_lane import aim_pkg::*; (
  input  logic  clk,
  input  logic  load_en,
  input  data_t b_in,
  input  data_t a_in,
  output logic  hit
);

  data_t b_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      b_r <= b_in;
    end
  end

  assign hit = (a_in == b_r);

endmodule

// ===== rtl/aim_merge.sv =====
// Merge stage: keeps the hit mask of every A row and walks them in order into
// the output register, one result per cycle at most; output stalls hold it. Depends on aim_pkg, aim_if.
module aim_merge import aim_pkg::*; #(
  parameter int SET_SIZE = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  row_wr_t   row_wr,
  output row_t      sel_row,
  input  data_t     row_value,
  output logic      busy,
  aim_out_if.source out_ch
);

  localparam logic M_IDLE = 1'b0;
  localparam logic M_EMIT = 1'b1;

  logic  st_r;
  row_t  row_r;
  pos_t  cnt_r;
  logic  any_r;
  mask_t mask_r [STORE_DEPTH];

  logic  out_valid_r;
  data_t out_value_r;
  pos_t  out_pos_r;
  logic  out_found_r;
  logic  out_last_r;

  mask_t cur;
  mask_t cleared;
  row_t  low;
  logic  later_nz;
  logic  slot_free;
  logic  emit_hit;
  logic  emit_any;
  logic  hit_last;

  always_comb begin
    cur = mask_r[row_r];
    low = '0;
    for (int k = STORE_DEPTH - 1; k >= 0; k--) begin
      if (cur[k]) begin
        low = row_t'(k);
      end
    end
    cleared  = cur & ~(mask_t'(1) << low);
    later_nz = 1'b0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (k < SET_SIZE && row_t'(k) > row_r && mask_r[k] != '0) begin
        later_nz = 1'b1;
      end
    end
  end

  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit_hit  = (st_r == M_EMIT) && slot_free && any_r && (cur != '0);
  assign emit_any  = (st_r == M_EMIT) && slot_free && (!any_r || (cur != '0));
  assign hit_last  = (cleared == '0) && !later_nz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= M_IDLE;
      row_r       <= '0;
      cnt_r       <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_any) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        M_IDLE: begin
          if (row_wr.wr) begin
            any_r <= ((row_wr.row == '0) ? 1'b0 : any_r) | (row_wr.mask != '0);
            if (row_wr.fin) begin
              st_r  <= M_EMIT;
              row_r <= '0;
              cnt_r <= '0;
            end
          end
        end
        M_EMIT: begin
          if (slot_free) begin
            if (!any_r) begin
              // empty intersection: single marker result
              st_r <= M_IDLE;
            end else if (cur == '0) begin
              row_r <= row_r + 1'b1;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              if (hit_last) begin
                st_r <= M_IDLE;
              end else if (cleared == '0) begin
                row_r <= row_r + 1'b1;
              end
            end
          end
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == M_IDLE && row_wr.wr) begin
      mask_r[row_wr.row] <= row_wr.mask;
    end else if (emit_hit) begin
      mask_r[row_r] <= cleared;
    end
    if (st_r == M_EMIT && slot_free && !any_r) begin
      out_value_r <= '0;
      out_pos_r   <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (emit_hit) begin
      out_value_r <= row_value;
      out_pos_r   <= cnt_r;
      out_found_r <= 1'b1;
      out_last_r  <= hit_last;
    end
  end

  assign sel_row             = row_r;
  assign busy                = (st_r == M_EMIT);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.match_value  = out_value_r;
  assign out_ch.out_position = out_pos_r;
  assign out_ch.match_found  = out_found_r;
  assign out_ch.last         = out_last_r;

endmodule

// ===== rtl/array_intersection_match_core.sv =====
// Top level of the array intersection match block: pair store, compare lanes
// and merge stage. Depends on aim_pkg, aim_if, aim_lane, aim_merge.
//
//   channel  dir  transfer moves
//   in_ch    in   one (a_value, b_value) pair
//   out_ch   out  match_value, out_position, match_found, last
//
// A set is loaded one pair per cycle while in_ch.ready is high, compared one A
// row per cycle against SET_SIZE B lanes, then emitted one result at a time,
// with a step per hitless row ahead of the last hit (a single marker result
// for an empty intersection); output stalls hold the merge stage.
// in_ch.ready is low during compare and until the final result of a set has
// entered the output register.
// Reset clears the control state; the stores need no clearing.
module array_intersection_match_core import aim_pkg::*; #(
  parameter int SET_SIZE = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  aim_in_if.sink    in_ch,
  aim_out_if.source out_ch
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_CMP  = 1'b1;

  logic    st_r;
  row_t    idx_r;
  data_t   a_store_r [STORE_DEPTH];
  data_t   a_bcast;
  mask_t   hit;
  row_wr_t row_wr;
  row_t    sel_row;
  data_t   row_value;
  logic    busy;
  logic    in_fire;
  logic    idx_fin;

  assign in_ch.ready = (st_r == ST_LOAD) && !busy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign idx_fin     = (idx_r == row_t'(SET_SIZE - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_LOAD;
      idx_r <= '0;
    end else begin
      unique case (st_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (idx_fin) begin
              st_r  <= ST_CMP;
              idx_r <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_CMP: begin
          if (idx_fin) begin
            st_r  <= ST_LOAD;
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: st_r <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_store_r[idx_r] <= in_ch.a_value;
    end
  end

  assign a_bcast   = a_store_r[idx_r];
  assign row_value = a_store_r[sel_row];

  for (genvar j = 0; j < SET_SIZE; j++) begin : g_lane
    aim_lane u_lane (
      .clk     (clk),
      .load_en (in_fire && (idx_r == row_t'(j))),
      .b_in    (in_ch.b_value),
      .a_in    (a_bcast),
      .hit     (hit[j])
    );
  end
  for (genvar j = SET_SIZE; j < STORE_DEPTH; j++) begin : g_pad
    assign hit[j] = 1'b0;
  end

  assign row_wr.wr   = (st_r == ST_CMP);
  assign row_wr.fin  = idx_fin;
  assign row_wr.row  = idx_r;
  assign row_wr.mask = hit;

  aim_merge #(.SET_SIZE(SET_SIZE)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_wr    (row_wr),
    .sel_row   (sel_row),
    .row_value (row_value),
    .busy      (busy),
    .out_ch    (out_ch)
  );

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.match_found) |-> out_ch.last)
    else $error("empty marker without last");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |-> busy)
    else $error("non-final result with merge stage idle");

  a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !((st_r == ST_CMP) && busy))
    else $error("compare overlaps emission");

  a_load_idx: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (int'(idx_r) < SET_SIZE))
    else $error("pair index beyond set size");

endmodule
